// ===== hdl/ccr_pkg.sv =====
`timescale 1ns / 1ps

package ccr_pkg;

  // field widths
  localparam int PosW   = 13;
  localparam int RadW   = 10;
  localparam int VelW   = 16;
  localparam int FracW  = 16;
  localparam int SpeedW = 16;

  // look-ahead fraction after reset, about 0.01 in Q0.16
  localparam logic [FracW-1:0] LookaheadReset = 16'd655;

  // default queue depths
  localparam int MidqDepthDefault = 8;
  localparam int OutqDepthDefault = 64;

  // total mass r1^2 + r2^2
  localparam int MassW  = 2 * RadW + 1;
  // rounded dividend magnitude of the exchange
  localparam int DivW   = 39;
  // quotient magnitude, stays below three times the velocity range
  localparam int QuotW  = VelW + 2;
  // squared speed and its root
  localparam int SqW    = 2 * VelW;
  localparam int RootW  = SpeedW;

  typedef struct packed {
    logic signed [PosW-1:0] first_x;
    logic signed [PosW-1:0] first_y;
    logic        [RadW-1:0] first_radius;
    logic signed [VelW-1:0] first_vel_x;
    logic signed [VelW-1:0] first_vel_y;
    logic signed [PosW-1:0] second_x;
    logic signed [PosW-1:0] second_y;
    logic        [RadW-1:0] second_radius;
    logic signed [VelW-1:0] second_vel_x;
    logic signed [VelW-1:0] second_vel_y;
  } pair_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                   hit;
    logic        [RadW-1:0] r1;
    logic        [RadW-1:0] r2;
    logic signed [VelW-1:0] vx1;
    logic signed [VelW-1:0] vy1;
    logic signed [VelW-1:0] vx2;
    logic signed [VelW-1:0] vy2;
  } mid_item_t;

  typedef struct packed {
    logic                     collided;
    logic signed [VelW-1:0]   first_new_vel_x;
    logic signed [VelW-1:0]   first_new_vel_y;
    logic        [SpeedW-1:0] first_speed;
    logic signed [VelW-1:0]   second_new_vel_x;
    logic signed [VelW-1:0]   second_new_vel_y;
    logic        [SpeedW-1:0] second_speed;
  } result_t;

endpackage

// ===== hdl/ccr_front.sv =====
`timescale 1ns / 1ps

module ccr_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  ccr_pkg::pair_t           in_pair,
  input  logic [ccr_pkg::FracW-1:0] frac,
  output logic                     out_valid,
  output ccr_pkg::mid_item_t       out_item
);
  import ccr_pkg::*;

  localparam int DposW  = PosW + 1;
  localparam int DvelW  = VelW + 1;
  localparam int SqPosW = 2 * DposW;
  localparam int DistW  = SqPosW + 1;
  localparam int RsW    = RadW + 1;
  localparam int RsSqW  = 2 * RsW;
  localparam int ProdW  = DvelW + FracW + 1;
  localparam int ExW    = 25;
  localparam int CrossW = DposW + ExW;
  localparam int DotW   = CrossW + 1;
  localparam int ExSqW  = 2 * ExW;
  localparam int NormW  = ExSqW + 1;
  // approach test is 2*a*2^16 + b < 0
  localparam int ApproachShift = FracW + 1;
  localparam int TestW  = DotW + ApproachShift + 1;
  localparam int RoundShift = 8;

  // round a Q.24 displacement to Q.16, half away from zero
  function automatic logic signed [ExW-1:0] round8(input logic signed [ProdW-1:0] v);
    logic [ProdW-1:0] mag;
    logic [ProdW-1:0] q;
    mag = v[ProdW-1] ? $unsigned(-v) : $unsigned(v);
    q   = (mag + (ProdW'(1) << (RoundShift - 1))) >> RoundShift;
    return v[ProdW-1] ? -$signed(ExW'(q)) : $signed(ExW'(q));
  endfunction

  logic signed [FracW:0] frac_s;
  assign frac_s = $signed({1'b0, frac});

  logic                    s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  mid_item_t               s1_item, s2_item, s3_item, s4_item, s5_item;
  logic signed [DposW-1:0] s1_dpx, s1_dpy, s2_dpx, s2_dpy, s3_dpx, s3_dpy;
  logic signed [DvelW-1:0] s1_dvx, s1_dvy;
  logic        [RsW-1:0]   s1_rs;
  logic signed [SqPosW-1:0] s2_dx2, s2_dy2;
  logic        [RsSqW-1:0] s2_rs2;
  logic signed [ProdW-1:0] s2_px, s2_py;
  logic                    s3_touch, s4_touch, s5_touch;
  logic signed [ExW-1:0]   s3_ex, s3_ey;
  logic signed [CrossW-1:0] s4_ax, s4_ay;
  logic signed [ExSqW-1:0] s4_bx, s4_by;
  logic signed [DotW-1:0]  s5_a;
  logic signed [NormW-1:0] s5_b;
  logic signed [DistW-1:0] d2;
  logic signed [TestW-1:0] test;

  // valid bits of the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // stage 1: differences and radius sum
  always_ff @(posedge clk) begin
    s1_dpx       <= DposW'(in_pair.second_x) - DposW'(in_pair.first_x);
    s1_dpy       <= DposW'(in_pair.second_y) - DposW'(in_pair.first_y);
    s1_dvx       <= DvelW'(in_pair.second_vel_x) - DvelW'(in_pair.first_vel_x);
    s1_dvy       <= DvelW'(in_pair.second_vel_y) - DvelW'(in_pair.first_vel_y);
    s1_rs        <= RsW'(in_pair.first_radius) + RsW'(in_pair.second_radius);
    s1_item.hit  <= 1'b0;
    s1_item.r1   <= in_pair.first_radius;
    s1_item.r2   <= in_pair.second_radius;
    s1_item.vx1  <= in_pair.first_vel_x;
    s1_item.vy1  <= in_pair.first_vel_y;
    s1_item.vx2  <= in_pair.second_vel_x;
    s1_item.vy2  <= in_pair.second_vel_y;
  end

  // stage 2: squares and look-ahead products
  always_ff @(posedge clk) begin
    s2_dx2  <= s1_dpx * s1_dpx;
    s2_dy2  <= s1_dpy * s1_dpy;
    s2_rs2  <= s1_rs * s1_rs;
    s2_px   <= s1_dvx * frac_s;
    s2_py   <= s1_dvy * frac_s;
    s2_dpx  <= s1_dpx;
    s2_dpy  <= s1_dpy;
    s2_item <= s1_item;
  end

  // stage 3: touch test and rounded displacement
  assign d2 = DistW'(s2_dx2) + DistW'(s2_dy2);

  always_ff @(posedge clk) begin
    s3_touch <= d2 <= $signed(DistW'(s2_rs2));
    s3_ex    <= round8(s2_px);
    s3_ey    <= round8(s2_py);
    s3_dpx   <= s2_dpx;
    s3_dpy   <= s2_dpy;
    s3_item  <= s2_item;
  end

  // stage 4: cross and square terms of the approach test
  always_ff @(posedge clk) begin
    s4_ax    <= s3_dpx * s3_ex;
    s4_ay    <= s3_dpy * s3_ey;
    s4_bx    <= s3_ex * s3_ex;
    s4_by    <= s3_ey * s3_ey;
    s4_touch <= s3_touch;
    s4_item  <= s3_item;
  end

  // stage 5: dot product and squared displacement
  always_ff @(posedge clk) begin
    s5_a     <= DotW'(s4_ax) + DotW'(s4_ay);
    s5_b     <= NormW'(s4_bx) + NormW'(s4_by);
    s5_touch <= s4_touch;
    s5_item  <= s4_item;
  end

  // approaching when the squared distance shrinks
  assign test = (TestW'(s5_a) <<< ApproachShift) + TestW'(s5_b);

  always_comb begin
    out_item     = s5_item;
    out_item.hit = s5_touch && test[TestW-1];
  end

  assign out_valid = s5_valid;

endmodule

// ===== hdl/ccr_div.sv =====
`timescale 1ns / 1ps

module ccr_div (
  input  logic                      clk,
  input  logic [ccr_pkg::DivW-1:0]  dividend,
  input  logic [ccr_pkg::MassW-1:0] divisor,
  output logic [ccr_pkg::QuotW-1:0] quotient
);
  import ccr_pkg::*;

  logic [DivW-1:0]  rem_q [QuotW-1];
  logic [MassW-1:0] den_q [QuotW-1];
  logic [QuotW-1:0] quo_q [QuotW];

  // restoring division, one quotient bit per stage, msb first
  for (genvar k = 0; k < QuotW; k++) begin : g_stage
    localparam int Shift = QuotW - 1 - k;
    logic [DivW-1:0]  rem_in;
    logic [DivW-1:0]  trial;
    logic [MassW-1:0] den_in;
    logic [QuotW-1:0] quo_in;
    logic             take;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = DivW'(den_in) << Shift;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk) begin
      quo_q[k] <= take ? (quo_in | (QuotW'(1) << Shift)) : quo_in;
    end

    if (k < QuotW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_q[k] <= take ? rem_in - trial : rem_in;
        den_q[k] <= den_in;
      end
    end
  end

  assign quotient = quo_q[QuotW-1];

endmodule

// ===== hdl/ccr_sqrt.sv =====
`timescale 1ns / 1ps

module ccr_sqrt (
  input  logic                      clk,
  input  logic [ccr_pkg::SqW-1:0]   radicand,
  output logic [ccr_pkg::RootW-1:0] root
);
  import ccr_pkg::*;

  localparam int TrW = SqW + 2;

  logic [SqW-1:0]   rem_q [RootW];
  logic [RootW-1:0] q_q   [RootW];

  // digit-by-digit root, one result bit per stage, rem holds n - q^2
  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic [SqW-1:0]   rem_in;
    logic [RootW-1:0] q_in;
    logic [TrW-1:0]   trial;

    if (k == 0) begin : g_first
      assign rem_in = radicand;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign trial = (TrW'(q_in) << (Bit + 1)) + (TrW'(1) << (2 * Bit));

    always_ff @(posedge clk) begin
      if (TrW'(rem_in) >= trial) begin
        rem_q[k] <= rem_in - SqW'(trial);
        q_q[k]   <= q_in | (RootW'(1) << Bit);
      end else begin
        rem_q[k] <= rem_in;
        q_q[k]   <= q_in;
      end
    end
  end

  // round to nearest: step up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    root <= q_q[RootW-1] + RootW'(rem_q[RootW-1] > SqW'(q_q[RootW-1]));
  end

endmodule

// ===== hdl/ccr_back.sv =====
`timescale 1ns / 1ps

module ccr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ccr_pkg::mid_item_t in_item,
  output logic               out_valid,
  output ccr_pkg::result_t   out_res
);
  import ccr_pkg::*;

  localparam int Lanes    = 4;
  localparam int MassSqW  = 2 * RadW;
  localparam int MDiffW   = MassW + 1;
  localparam int PrW      = MDiffW + VelW;
  localparam int NumW     = DivW;
  localparam int VdDepth  = RootW + 3;
  localparam int VelMax   = 2 ** (VelW - 1) - 1;
  // masses of one each when both radii are zero
  localparam logic [MassW-1:0] UnitTotal = MassW'(2);

  // lanes: first x, first y, second x, second y
  typedef struct packed {
    logic                       hit;
    logic [Lanes-1:0]           neg;
    logic [Lanes-1:0][VelW-1:0] vel;
  } div_side_t;

  typedef struct packed {
    logic                       hit;
    logic [Lanes-1:0][VelW-1:0] vel;
  } vel_side_t;

  function automatic logic signed [VelW-1:0] sat_q(input logic [QuotW-1:0] q,
                                                    input logic neg);
    logic signed [VelW-1:0] r;
    if (neg) begin
      r = (q > QuotW'(VelMax + 1)) ? $signed(VelW'(VelMax + 1)) : -$signed(VelW'(q));
    end else begin
      r = (q > QuotW'(VelMax)) ? $signed(VelW'(VelMax)) : $signed(VelW'(q));
    end
    return r;
  endfunction

  logic                     b1_valid, b2_valid, b3_valid, b4_valid;
  mid_item_t                b1_item, b2_item, b3_item;
  logic [MassSqW-1:0]       b1_m1, b1_m2;
  logic                     zero_mass;
  logic [MassW-1:0]         b2_mt, b3_mt, b4_mt;
  logic signed [MDiffW-1:0] b2_diff, b2_ndiff, b2_tm1, b2_tm2;
  logic signed [PrW-1:0]    b3_p [Lanes];
  logic signed [PrW-1:0]    b3_q [Lanes];
  logic signed [NumW-1:0]   num  [Lanes];
  logic [DivW-1:0]          b4_mag [Lanes];
  div_side_t                b4_side;
  logic [MassW-1:0]         half_mt;
  logic [QuotW-1:0]         quo [Lanes];
  logic [QuotW-1:0]         dv_valid;
  div_side_t                dside [QuotW];
  logic                     sat_valid;
  logic                     sat_hit;
  logic signed [VelW-1:0]   sat_vel [Lanes];
  logic [SqW-1:0]           sq [Lanes];
  logic [SqW-1:0]           sum1, sum2;
  logic [VdDepth-1:0]       vv;
  vel_side_t                vd [VdDepth];
  logic [RootW-1:0]         root1, root2;

  // valid bits of the fixed stages
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      b3_valid  <= 1'b0;
      b4_valid  <= 1'b0;
      dv_valid  <= '0;
      sat_valid <= 1'b0;
      vv        <= '0;
    end else begin
      b1_valid  <= in_valid;
      b2_valid  <= b1_valid;
      b3_valid  <= b2_valid;
      b4_valid  <= b3_valid;
      dv_valid  <= {dv_valid[QuotW-2:0], b4_valid};
      sat_valid <= dv_valid[QuotW-1];
      vv        <= {vv[VdDepth-2:0], sat_valid};
    end
  end

  // b1: masses
  always_ff @(posedge clk) begin
    b1_m1   <= in_item.r1 * in_item.r1;
    b1_m2   <= in_item.r2 * in_item.r2;
    b1_item <= in_item;
  end

  // b2: mass difference, doubled masses, total
  assign zero_mass = (b1_m1 == '0) && (b1_m2 == '0);

  always_ff @(posedge clk) begin
    if (zero_mass) begin
      b2_mt    <= UnitTotal;
      b2_diff  <= '0;
      b2_ndiff <= '0;
      b2_tm1   <= MDiffW'(UnitTotal);
      b2_tm2   <= MDiffW'(UnitTotal);
    end else begin
      b2_mt    <= MassW'(b1_m1) + MassW'(b1_m2);
      b2_diff  <= $signed(MDiffW'(b1_m1)) - $signed(MDiffW'(b1_m2));
      b2_ndiff <= $signed(MDiffW'(b1_m2)) - $signed(MDiffW'(b1_m1));
      b2_tm1   <= $signed(MDiffW'(b1_m1) << 1);
      b2_tm2   <= $signed(MDiffW'(b1_m2) << 1);
    end
    b2_item <= b1_item;
  end

  // b3: weighted velocity terms
  always_ff @(posedge clk) begin
    b3_p[0] <= b2_diff * b2_item.vx1;
    b3_q[0] <= b2_tm2 * b2_item.vx2;
    b3_p[1] <= b2_diff * b2_item.vy1;
    b3_q[1] <= b2_tm2 * b2_item.vy2;
    b3_p[2] <= b2_ndiff * b2_item.vx2;
    b3_q[2] <= b2_tm1 * b2_item.vx1;
    b3_p[3] <= b2_ndiff * b2_item.vy2;
    b3_q[3] <= b2_tm1 * b2_item.vy1;
    b3_mt   <= b2_mt;
    b3_item <= b2_item;
  end

  // b4: numerators, sign and rounded dividend magnitude
  assign half_mt = b3_mt >> 1;

  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      num[j] = NumW'(b3_p[j]) + NumW'(b3_q[j]);
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < Lanes; j++) begin
      b4_mag[j]      <= (num[j][NumW-1] ? $unsigned(-num[j]) : $unsigned(num[j]))
                        + DivW'(half_mt);
      b4_side.neg[j] <= num[j][NumW-1];
    end
    b4_side.hit    <= b3_item.hit;
    b4_side.vel[0] <= b3_item.vx1;
    b4_side.vel[1] <= b3_item.vy1;
    b4_side.vel[2] <= b3_item.vx2;
    b4_side.vel[3] <= b3_item.vy2;
    b4_mt          <= b3_mt;
  end

  // dividers, one per lane
  for (genvar j = 0; j < Lanes; j++) begin : g_div
    ccr_div u_div (
      .clk      (clk),
      .dividend (b4_mag[j]),
      .divisor  (b4_mt),
      .quotient (quo[j])
    );
  end

  // side data alongside the dividers
  always_ff @(posedge clk) begin
    dside[0] <= b4_side;
    for (int k = 1; k < QuotW; k++) begin
      dside[k] <= dside[k-1];
    end
  end

  // saturate, or pass the velocities through on no collision
  always_ff @(posedge clk) begin
    for (int j = 0; j < Lanes; j++) begin
      sat_vel[j] <= dside[QuotW-1].hit ? sat_q(quo[j], dside[QuotW-1].neg[j])
                                       : $signed(dside[QuotW-1].vel[j]);
    end
    sat_hit <= dside[QuotW-1].hit;
  end

  // squares, then squared speeds
  always_ff @(posedge clk) begin
    for (int j = 0; j < Lanes; j++) begin
      sq[j] <= sat_vel[j] * sat_vel[j];
    end
    sum1 <= sq[0] + sq[1];
    sum2 <= sq[2] + sq[3];
  end

  ccr_sqrt u_sqrt1 (
    .clk      (clk),
    .radicand (sum1),
    .root     (root1)
  );

  ccr_sqrt u_sqrt2 (
    .clk      (clk),
    .radicand (sum2),
    .root     (root2)
  );

  // velocities alongside the square roots
  always_ff @(posedge clk) begin
    vd[0].hit <= sat_hit;
    for (int j = 0; j < Lanes; j++) begin
      vd[0].vel[j] <= sat_vel[j];
    end
    for (int k = 1; k < VdDepth; k++) begin
      vd[k] <= vd[k-1];
    end
  end

  // result beat
  always_comb begin
    out_res.collided         = vd[VdDepth-1].hit;
    out_res.first_new_vel_x  = $signed(vd[VdDepth-1].vel[0]);
    out_res.first_new_vel_y  = $signed(vd[VdDepth-1].vel[1]);
    out_res.first_speed      = root1;
    out_res.second_new_vel_x = $signed(vd[VdDepth-1].vel[2]);
    out_res.second_new_vel_y = $signed(vd[VdDepth-1].vel[3]);
    out_res.second_speed     = root2;
  end

  assign out_valid = vv[VdDepth-1];

endmodule

// ===== hdl/circle_collision_response_unit.sv =====
`timescale 1ns / 1ps
// throughput: one pair per cycle while full is low and pop keeps up, set by the fully pipelined dividers and root units
// the front pipeline is 5 stages, the back 42 stages (18-stage dividers, 17-stage roots)
// full and pop backpressure are handled by credit counters on the two queues
// rst is synchronous: it empties both queues, clears valid bits and sets the
// look-ahead fraction to 655
module circle_collision_response_unit #(
  parameter int MIDQ_DEPTH = ccr_pkg::MidqDepthDefault,
  parameter int OUTQ_DEPTH = ccr_pkg::OutqDepthDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic signed [ccr_pkg::PosW-1:0]  first_x,
  input  logic signed [ccr_pkg::PosW-1:0]  first_y,
  input  logic        [ccr_pkg::RadW-1:0]  first_radius,
  input  logic signed [ccr_pkg::VelW-1:0]  first_vel_x,
  input  logic signed [ccr_pkg::VelW-1:0]  first_vel_y,
  input  logic signed [ccr_pkg::PosW-1:0]  second_x,
  input  logic signed [ccr_pkg::PosW-1:0]  second_y,
  input  logic        [ccr_pkg::RadW-1:0]  second_radius,
  input  logic signed [ccr_pkg::VelW-1:0]  second_vel_x,
  input  logic signed [ccr_pkg::VelW-1:0]  second_vel_y,
  output logic                             empty,
  input  logic                             pop,
  output logic                             collided,
  output logic signed [ccr_pkg::VelW-1:0]  first_new_vel_x,
  output logic signed [ccr_pkg::VelW-1:0]  first_new_vel_y,
  output logic        [ccr_pkg::SpeedW-1:0] first_speed,
  output logic signed [ccr_pkg::VelW-1:0]  second_new_vel_x,
  output logic signed [ccr_pkg::VelW-1:0]  second_new_vel_y,
  output logic        [ccr_pkg::SpeedW-1:0] second_speed,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic        [ccr_pkg::FracW-1:0] cfg_data
);
  import ccr_pkg::*;

  localparam int MqCntW = $clog2(MIDQ_DEPTH + 1);
  localparam int MqPtrW = $clog2(MIDQ_DEPTH);
  localparam int OqCntW = $clog2(OUTQ_DEPTH + 1);
  localparam int OqPtrW = $clog2(OUTQ_DEPTH);

  logic [FracW-1:0]  lookahead;
  pair_t             in_pair;
  logic              accept, pop_acc;
  logic              fr_valid, bk_valid;
  mid_item_t         fr_item, mq_head;
  result_t           bk_res, out_res;
  logic [MqCntW-1:0] front_used, front_used_next, mq_count;
  logic [MqPtrW-1:0] mq_wr, mq_rd;
  mid_item_t         mq_mem [MIDQ_DEPTH];
  logic              mq_pop;
  logic [OqCntW-1:0] back_used, back_used_next, oq_count;
  logic [OqPtrW-1:0] oq_wr, oq_rd;
  result_t           oq_mem [OUTQ_DEPTH];
  logic              oq_load, out_full;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lookahead <= LookaheadReset;
    end else if (cfg_valid) begin
      lookahead <= cfg_data;
    end
  end

  // input beat
  assign accept = push && !full;
  assign full   = front_used == MqCntW'(MIDQ_DEPTH);

  always_comb begin
    in_pair.first_x       = first_x;
    in_pair.first_y       = first_y;
    in_pair.first_radius  = first_radius;
    in_pair.first_vel_x   = first_vel_x;
    in_pair.first_vel_y   = first_vel_y;
    in_pair.second_x      = second_x;
    in_pair.second_y      = second_y;
    in_pair.second_radius = second_radius;
    in_pair.second_vel_x  = second_vel_x;
    in_pair.second_vel_y  = second_vel_y;
  end

  ccr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_pair   (in_pair),
    .frac      (lookahead),
    .out_valid (fr_valid),
    .out_item  (fr_item)
  );

  // front credits: items in the front pipeline plus the middle queue
  always_comb begin
    unique case ({accept, mq_pop})
      2'b10:   front_used_next = front_used + MqCntW'(1);
      2'b01:   front_used_next = front_used - MqCntW'(1);
      default: front_used_next = front_used;
    endcase
  end

  // middle queue between classification and exchange
  assign mq_head = mq_mem[mq_rd];
  assign mq_pop  = (mq_count != '0) && (back_used != OqCntW'(OUTQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      front_used <= '0;
      mq_count   <= '0;
      mq_wr      <= '0;
      mq_rd      <= '0;
    end else begin
      front_used <= front_used_next;
      mq_count   <= mq_count + MqCntW'(fr_valid) - MqCntW'(mq_pop);
      if (fr_valid) begin
        mq_wr <= (mq_wr == MqPtrW'(MIDQ_DEPTH - 1)) ? '0 : mq_wr + MqPtrW'(1);
      end
      if (mq_pop) begin
        mq_rd <= (mq_rd == MqPtrW'(MIDQ_DEPTH - 1)) ? '0 : mq_rd + MqPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fr_valid) begin
      mq_mem[mq_wr] <= fr_item;
    end
  end

  ccr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mq_pop),
    .in_item   (mq_head),
    .out_valid (bk_valid),
    .out_res   (bk_res)
  );

  // back credits: items in the back pipeline, the result queue and the output register
  assign pop_acc = pop && !empty;

  always_comb begin
    unique case ({mq_pop, pop_acc})
      2'b10:   back_used_next = back_used + OqCntW'(1);
      2'b01:   back_used_next = back_used - OqCntW'(1);
      default: back_used_next = back_used;
    endcase
  end

  // result queue with registered read into the output register
  assign oq_load = (oq_count != '0) && (!out_full || pop_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      back_used <= '0;
      oq_count  <= '0;
      oq_wr     <= '0;
      oq_rd     <= '0;
      out_full  <= 1'b0;
    end else begin
      back_used <= back_used_next;
      oq_count  <= oq_count + OqCntW'(bk_valid) - OqCntW'(oq_load);
      if (bk_valid) begin
        oq_wr <= (oq_wr == OqPtrW'(OUTQ_DEPTH - 1)) ? '0 : oq_wr + OqPtrW'(1);
      end
      if (oq_load) begin
        oq_rd <= (oq_rd == OqPtrW'(OUTQ_DEPTH - 1)) ? '0 : oq_rd + OqPtrW'(1);
      end
      if (oq_load) begin
        out_full <= 1'b1;
      end else if (pop_acc) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bk_valid) begin
      oq_mem[oq_wr] <= bk_res;
    end
    if (oq_load) begin
      out_res <= oq_mem[oq_rd];
    end
  end

  // result beat
  assign empty            = !out_full;
  assign collided         = out_res.collided;
  assign first_new_vel_x  = out_res.first_new_vel_x;
  assign first_new_vel_y  = out_res.first_new_vel_y;
  assign first_speed      = out_res.first_speed;
  assign second_new_vel_x = out_res.second_new_vel_x;
  assign second_new_vel_y = out_res.second_new_vel_y;
  assign second_speed     = out_res.second_speed;

  // the front never writes into a full middle queue
  a_mq_room: assert property (@(posedge clk) disable iff (rst)
    fr_valid |-> (mq_count < MqCntW'(MIDQ_DEPTH)))
    else $error("middle queue overflow");

  // the back never writes into a full result queue
  a_oq_room: assert property (@(posedge clk) disable iff (rst)
    bk_valid |-> (oq_count < OqCntW'(OUTQ_DEPTH)))
    else $error("result queue overflow");

  // front credits cover every queued item
  a_front_credit: assert property (@(posedge clk) disable iff (rst)
    front_used >= mq_count)
    else $error("front credit below middle queue fill");

  // back credits cover every queued and presented result
  a_back_credit: assert property (@(posedge clk) disable iff (rst)
    {1'b0, back_used} >= ({1'b0, oq_count} + {{OqCntW{1'b0}}, out_full}))
    else $error("back credit below result queue fill");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ccr_pkg::*;

  // expected results for accepted circle pairs, oldest first
  class collision_scoreboard;
    result_t pending[$];
    logic [FracW-1:0] frac;
    int errors;

    function new();
      frac = LookaheadReset;
      errors = 0;
    endfunction

    // round a Q.24 product to Q.16, half away from zero
    function longint shift8_round(longint v);
      longint q;
      q = ((v < 0 ? -v : v) + 128) >>> 8;
      return v < 0 ? -q : q;
    endfunction

    function longint exchange_vel(longint num, longint den);
      longint q;
      q = ((num < 0 ? -num : num) + den / 2) / den;
      if (num < 0) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
    endfunction

    function longint magnitude(longint vx, longint vy);
      longint n, r, t;
      n = vx * vx + vy * vy;
      r = 0;
      for (int k = 15; k >= 0; k--) begin
        t = r | (longint'(1) << k);
        if (t * t <= n) r = t;
      end
      if (n - r * r > r) r = r + 1;
      return r;
    endfunction

    function void note_pair(pair_t p);
      longint x1, y1, x2, y2, r1, r2, vx1, vy1, vx2, vy2, f;
      longint dpx, dpy, d2, rs, ex, ey, a, b, m1, m2, mt;
      longint n1x, n1y, n2x, n2y;
      logic hit;
      result_t r;
      x1 = p.first_x; y1 = p.first_y; r1 = p.first_radius;
      vx1 = p.first_vel_x; vy1 = p.first_vel_y;
      x2 = p.second_x; y2 = p.second_y; r2 = p.second_radius;
      vx2 = p.second_vel_x; vy2 = p.second_vel_y;
      f = frac;
      dpx = x2 - x1;
      dpy = y2 - y1;
      d2 = dpx * dpx + dpy * dpy;
      rs = r1 + r2;
      ex = shift8_round((vx2 - vx1) * f);
      ey = shift8_round((vy2 - vy1) * f);
      a = dpx * ex + dpy * ey;
      b = ex * ex + ey * ey;
      hit = (d2 <= rs * rs) && (a * 131072 + b < 0);
      n1x = vx1; n1y = vy1; n2x = vx2; n2y = vy2;
      if (hit) begin
        m1 = r1 * r1;
        m2 = r2 * r2;
        // two zero radii count as equal masses
        if (m1 + m2 == 0) begin
          m1 = 1;
          m2 = 1;
        end
        mt = m1 + m2;
        n1x = exchange_vel((m1 - m2) * vx1 + 2 * m2 * vx2, mt);
        n1y = exchange_vel((m1 - m2) * vy1 + 2 * m2 * vy2, mt);
        n2x = exchange_vel((m2 - m1) * vx2 + 2 * m1 * vx1, mt);
        n2y = exchange_vel((m2 - m1) * vy2 + 2 * m1 * vy1, mt);
      end
      r.collided = hit;
      r.first_new_vel_x = n1x[15:0];
      r.first_new_vel_y = n1y[15:0];
      r.first_speed = 16'(magnitude(n1x, n1y));
      r.second_new_vel_x = n2x[15:0];
      r.second_new_vel_y = n2y[15:0];
      r.second_speed = 16'(magnitude(n2x, n2y));
      pending.push_back(r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("collided", want.collided, got.collided);
      compare_field("first_new_vel_x", want.first_new_vel_x, got.first_new_vel_x);
      compare_field("first_new_vel_y", want.first_new_vel_y, got.first_new_vel_y);
      compare_field("first_speed", want.first_speed, got.first_speed);
      compare_field("second_new_vel_x", want.second_new_vel_x, got.second_new_vel_x);
      compare_field("second_new_vel_y", want.second_new_vel_y, got.second_new_vel_y);
      compare_field("second_speed", want.second_speed, got.second_speed);
    endfunction
  endclass

  logic clk, rst, push, full, empty, pop, cfg_valid, cfg_ready;
  logic signed [PosW-1:0] first_x, first_y, second_x, second_y;
  logic [RadW-1:0] first_radius, second_radius;
  logic signed [VelW-1:0] first_vel_x, first_vel_y, second_vel_x, second_vel_y;
  logic collided;
  logic signed [VelW-1:0] first_new_vel_x, first_new_vel_y, second_new_vel_x, second_new_vel_y;
  logic [SpeedW-1:0] first_speed, second_speed;
  logic [FracW-1:0] cfg_data;

  collision_scoreboard sb;
  int send_idle_pct, recv_stall_pct;
  bit hold_req;

  circle_collision_response_unit dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    pop = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop = 0;
        for (int c = 0; c < 500; c++) @(negedge clk);
        hold_req = 0;
      end
      pop = ($urandom_range(99, 0) >= recv_stall_pct);
      @(posedge clk);
      if (!rst && pop && empty === 1'b0)
        sb.check_result({collided, first_new_vel_x, first_new_vel_y, first_speed,
                         second_new_vel_x, second_new_vel_y, second_speed});
    end
  end

  task automatic push_pair(pair_t p);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      push = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    {first_x, first_y, first_radius, first_vel_x, first_vel_y,
     second_x, second_y, second_radius, second_vel_x, second_vel_y} = p;
    push = 1;
    do @(posedge clk); while (full);
    sb.note_pair(p);
    @(negedge clk);
  endtask

  task automatic drain_queue();
    push = 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_frac(logic [FracW-1:0] v);
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.frac = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(5, 0))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(int'($urandom_range(1024, 0)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly pairs near contact so that collisions actually occur
  function automatic pair_t random_pair();
    pair_t p;
    int rsum, dx, dy;
    p.first_vel_x = rand_vel();
    p.first_vel_y = rand_vel();
    p.second_vel_x = rand_vel();
    p.second_vel_y = rand_vel();
    if ($urandom_range(99, 0) < 25) begin
      p.first_x = 13'($urandom); p.first_y = 13'($urandom);
      p.second_x = 13'($urandom); p.second_y = 13'($urandom);
      p.first_radius = 10'($urandom); p.second_radius = 10'($urandom);
    end else begin
      case ($urandom_range(3, 0))
        0: begin p.first_radius = 10'($urandom); p.second_radius = 10'($urandom); end
        1: begin p.first_radius = '0; p.second_radius = 10'($urandom_range(40, 0)); end
        2: begin p.first_radius = 10'($urandom_range(1023, 900)); p.second_radius = 10'd1; end
        default: begin
          p.first_radius = 10'($urandom_range(64, 0));
          p.second_radius = 10'($urandom_range(64, 0));
        end
      endcase
      rsum = p.first_radius + p.second_radius;
      dx = int'($urandom_range(2 * rsum, 0)) - rsum;
      dy = int'($urandom_range(2 * rsum, 0)) - rsum;
      p.first_x = 13'(int'($urandom_range(4000, 0)) - 2000);
      p.first_y = 13'(int'($urandom_range(4000, 0)) - 2000);
      p.second_x = p.first_x + 13'(dx);
      p.second_y = p.first_y + 13'(dy);
      // approach along the center line most of the time
      if ($urandom_range(99, 0) < 60) begin
        p.first_vel_x = 16'(dx * int'($urandom_range(64, 1)));
        p.first_vel_y = 16'(dy * int'($urandom_range(64, 1)));
        p.second_vel_x = 16'(-dx * int'($urandom_range(64, 1)));
        p.second_vel_y = 16'(-dy * int'($urandom_range(64, 1)));
      end
    end
    return p;
  endfunction

  initial begin
    pair_t dir[$];
    logic [FracW-1:0] fracs[5];
    sb = new();
    rst = 1; push = 0; cfg_valid = 0; cfg_data = 0; hold_req = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    {first_x, first_y, first_radius, first_vel_x, first_vel_y,
     second_x, second_y, second_radius, second_vel_x, second_vel_y} = '0;
    repeat (6) @(negedge clk);
    rst = 0;

    // directed: extremes, head-on hits, exact touch, zero radii, saturation
    dir.push_back('0);
    dir.push_back('1);
    dir.push_back({13'd0, 13'd0, 10'd10, 16'h7fff, 16'h0000,
                   13'd15, 13'd0, 10'd10, 16'h8000, 16'h0000});
    dir.push_back({13'd0, 13'd0, 10'd3, 16'h0100, 16'h0100,
                   13'd3, 13'd4, 10'd2, 16'hff00, 16'hff00});
    dir.push_back({13'd0, 13'd0, 10'd3, 16'hff00, 16'hff00,
                   13'd3, 13'd4, 10'd2, 16'h0100, 16'h0100});
    dir.push_back({13'd0, 13'd0, 10'd1023, 16'h7fff, 16'h7fff,
                   13'd20, 13'd20, 10'd0, 16'h8000, 16'h8000});
    dir.push_back({13'd0, 13'd0, 10'd0, 16'h8000, 16'h8000,
                   13'd5, 13'd5, 10'd1023, 16'h7fff, 16'h7fff});
    dir.push_back({13'd7, 13'd7, 10'd0, 16'h0400, 16'h0000,
                   13'd7, 13'd7, 10'd0, 16'hfc00, 16'h0000});
    dir.push_back({13'h1000, 13'h1000, 10'd1023, 16'h7fff, 16'h7fff,
                   13'h0fff, 13'h0fff, 10'd1023, 16'h8000, 16'h8000});
    dir.push_back({13'h1000, 13'h1000, 10'd1023, 16'h8000, 16'h8000,
                   13'h1010, 13'h1010, 10'd1023, 16'h7fff, 16'h7fff});
    dir.push_back({13'd0, 13'd0, 10'd50, 16'h0200, 16'h0000,
                   13'd60, 13'd0, 10'd50, 16'hfe00, 16'h0000});
    dir.push_back({13'd0, 13'd0, 10'd50, 16'h0200, 16'h0000,
                   13'd60, 13'd0, 10'd50, 16'h0300, 16'h0000});
    dir.push_back({13'd100, 13'd0, 10'd1, 16'h0001, 16'h0000,
                   13'd101, 13'd0, 10'd1, 16'hffff, 16'h0000});
    foreach (dir[i]) push_pair(dir[i]);

    fracs[0] = LookaheadReset;
    fracs[1] = 16'hffff;
    fracs[2] = 16'h0000;
    fracs[3] = 16'($urandom);
    fracs[4] = 16'h0001;
    for (int ph = 0; ph < 5; ph++) begin
      drain_queue();
      write_frac(fracs[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      if (ph == 0) hold_req = 1;
      for (int n = 0; n < 280; n++) push_pair(random_pair());
    end

    drain_queue();
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
